// ----- rtl/gcl_pkg.sv -----
// package for the glyph coverage lookup: sizes, codes, entry and control types
// no dependencies; used by every other file of the block except gcl_ram
`timescale 1ns / 1ps

package gcl_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

  localparam int GLYPH_W     = 16;
  localparam int SLOT_W      = 8;
  localparam int FORMAT_W    = 2;
  localparam int ECOUNT_W    = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [FORMAT_W-1:0] FMT_GLYPHS = 2'd1;
  localparam logic [FORMAT_W-1:0] FMT_RANGES = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT  = 1'd1;

  typedef struct packed {
    logic [GLYPH_W-1:0] start_glyph;
    logic [GLYPH_W-1:0] end_glyph;
    logic [GLYPH_W-1:0] base;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [FORMAT_W-1:0] table_format;
    logic [ECOUNT_W-1:0] entry_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_SEARCH,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/gcl_if.sv -----
// channel interfaces: input items, result items and configuration writes
// depends on gcl_pkg for field widths
`timescale 1ns / 1ps

interface gcl_item_if import gcl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [SLOT_W-1:0]  entry_slot;
  logic [GLYPH_W-1:0] first_glyph;
  logic [GLYPH_W-1:0] last_glyph;
  logic [GLYPH_W-1:0] base_index;
  logic [GLYPH_W-1:0] query_glyph;

  modport source (output valid, op, entry_slot, first_glyph, last_glyph, base_index,
                  query_glyph, input ready);
  modport sink (input valid, op, entry_slot, first_glyph, last_glyph, base_index,
                query_glyph, output ready);
endinterface

interface gcl_result_if import gcl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               covered;
  logic [GLYPH_W-1:0] coverage_index;
  logic               order_error;

  modport source (output valid, covered, coverage_index, order_error, input ready);
  modport sink (input valid, covered, coverage_index, order_error, output ready);
endinterface

interface gcl_cfg_if import gcl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/gcl_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no package dependencies
`timescale 1ns / 1ps

module gcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gcl_ctrl.sv -----
// sequencer for loads and binary-search lookups over the entry ram, with result register
// depends on gcl_pkg and the channel interfaces
`timescale 1ns / 1ps

module gcl_ctrl import gcl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  gcl_item_if.sink            item,
  gcl_result_if.source        result,
  output mem_req_t            mem_req,
  input  entry_t              mem_rdata
);

  state_t state, state_next;

  logic               op_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [GLYPH_W-1:0] first_q, last_q, base_q, query_q;
  logic [COUNT_W-1:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic               covered, covered_next;
  logic [GLYPH_W-1:0] cov_index, cov_index_next;
  logic               err, err_next;

  logic               res_valid;
  logic               res_covered;
  logic [GLYPH_W-1:0] res_index;
  logic               res_error;

  logic               accept;
  logic               push;
  logic               slot_ok;
  logic               ranges;
  logic [GLYPH_W-1:0] probe_end;
  logic [COUNT_W-1:0] count_sat;
  logic               found;
  logic [COUNT_W-1:0] plo, phi;

  function automatic logic [COUNT_W-1:0] mid_of(input logic [COUNT_W-1:0] l,
                                                input logic [COUNT_W-1:0] h);
    logic [COUNT_W-1:0] d;
    d = h - l;
    return l + (d >> 1);
  endfunction

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign push       = (state == ST_DONE) && (!res_valid || result.ready);
  assign slot_ok    = (32'(slot_q) < MAX_ENTRIES);
  assign ranges     = (cfg.table_format == FMT_RANGES);
  assign probe_end  = ranges ? mem_rdata.end_glyph : mem_rdata.start_glyph;
  assign count_sat  = (32'(cfg.entry_count) > MAX_ENTRIES) ? COUNT_W'(MAX_ENTRIES)
                                                            : COUNT_W'(cfg.entry_count);

  // next state
  always_comb begin
    state_next = state;
    found      = (query_q >= mem_rdata.start_glyph) && (query_q <= probe_end);
    plo        = (query_q < mem_rdata.start_glyph) ? lo : mid + 1'b1;
    phi        = (query_q < mem_rdata.start_glyph) ? mid : hi;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.op == OP_LOOKUP) ? ST_SEARCH : ST_LOAD_RD;
        end
      end
      ST_LOAD_RD: state_next = ST_LOAD_WR;
      ST_LOAD_WR: state_next = ST_DONE;
      ST_SEARCH:  state_next = (lo < hi) ? ST_PROBE : ST_DONE;
      ST_PROBE: begin
        if (found || !(plo < phi)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_req        = '0;
    mem_req.waddr  = ADDR_W'(slot_q);
    mem_req.raddr  = ADDR_W'(mid_of(lo, hi));
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    covered_next   = covered;
    cov_index_next = cov_index;
    err_next       = err;
    if (ranges) begin
      mem_req.wdata = '{start_glyph: first_q, end_glyph: last_q, base: base_q};
    end else begin
      mem_req.wdata = '{start_glyph: first_q, end_glyph: first_q, base: '0};
    end
    unique case (state)
      ST_IDLE: begin
        lo_next        = '0;
        hi_next        = count_sat;
        covered_next   = 1'b0;
        cov_index_next = '0;
        err_next       = 1'b0;
      end
      ST_LOAD_RD: begin
        // previous entry, for the order check
        mem_req.raddr = ADDR_W'(SLOT_W'(slot_q - 1'b1));
      end
      ST_LOAD_WR: begin
        mem_req.we = slot_ok;
        err_next   = slot_ok && (slot_q != '0) && (first_q <= mem_rdata.end_glyph);
      end
      ST_SEARCH: begin
        mid_next = mid_of(lo, hi);
      end
      ST_PROBE: begin
        if (found) begin
          covered_next = 1'b1;
          if (ranges) begin
            cov_index_next = mem_rdata.base + (query_q - mem_rdata.start_glyph);
          end else begin
            cov_index_next = GLYPH_W'(mid);
          end
        end else begin
          // next probe is issued straight away
          lo_next       = plo;
          hi_next       = phi;
          mid_next      = mid_of(plo, phi);
          mem_req.raddr = ADDR_W'(mid_of(plo, phi));
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= item.op;
      slot_q  <= item.entry_slot;
      first_q <= item.first_glyph;
      last_q  <= item.last_glyph;
      base_q  <= item.base_index;
      query_q <= item.query_glyph;
    end
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    covered   <= covered_next;
    cov_index <= cov_index_next;
    err       <= err_next;
    if (push) begin
      res_covered <= (op_q == OP_LOOKUP) && covered;
      res_index   <= (op_q == OP_LOOKUP) ? cov_index : '0;
      res_error   <= (op_q == OP_LOAD) && err;
    end
  end

  assign result.valid          = res_valid;
  assign result.covered        = res_covered;
  assign result.coverage_index = res_index;
  assign result.order_error    = res_error;

endmodule

// ----- rtl/glyph_coverage_lookup.sv -----
// load: LOAD_RD (read of the previous entry), LOAD_WR (write and order check), then DONE;
// lookup: SEARCH, then one PROBE per ram read, at most log2(entries)+1 probes, then DONE
// one item at a time; the single read port of the entry ram sets the probe rate
// a finished result sits in an output register while the next item is taken
// reset: format = single glyphs, entry count = 0; entry ram contents are not cleared
// top level of the glyph coverage lookup; depends on gcl_pkg, gcl_if, gcl_ram, gcl_ctrl
`timescale 1ns / 1ps

module glyph_coverage_lookup import gcl_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  gcl_item_if.sink      item,
  gcl_result_if.source  result,
  gcl_cfg_if.sink       cfg
);

  cfg_t     cfg_regs;
  mem_req_t mem_req;
  entry_t   mem_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.table_format <= FMT_GLYPHS;
      cfg_regs.entry_count  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FORMAT: cfg_regs.table_format <= cfg.data[FORMAT_W-1:0];
        REG_COUNT:  cfg_regs.entry_count  <= cfg.data[ECOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  gcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .item      (item),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  gcl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/gcl_checker.sv -----
// port-level checks on the glyph coverage lookup, attached by bind
// depends on gcl_pkg and the top level's ports
`timescale 1ns / 1ps

module gcl_checker import gcl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               covered,
  input logic [GLYPH_W-1:0] coverage_index,
  input logic               order_error
);

  logic       in_acc, out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != '0))
    else $error("result shown with no item outstanding");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("second item taken while one is in work");

  a_uncovered_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !covered) |-> (coverage_index == '0))
    else $error("coverage index not zero for an uncovered result");

  a_error_only_on_load: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(covered && order_error))
    else $error("result flags both covered and order error");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(covered)
                                   && $stable(coverage_index) && $stable(order_error)))
    else $error("stalled result changed");

endmodule

bind glyph_coverage_lookup gcl_checker u_gcl_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .covered        (result.covered),
  .coverage_index (result.coverage_index),
  .order_error    (result.order_error)
);

// ----- sim/gcl_coverage_checker.sv -----
// checker for the glyph coverage lookup: watches the item, result and config
// channels, predicts each result item and compares it; depends on gcl_pkg and gcl_if
`timescale 1ns / 1ps

module gcl_coverage_checker import gcl_pkg::*; (
  input  logic clk,
  input  logic rst,
  gcl_item_if   item,
  gcl_result_if result,
  gcl_cfg_if    cfg,
  output int    fail_count,
  output int    pending,
  output int    loads_seen,
  output int    order_errs_seen,
  output int    lookups_seen,
  output int    hits_seen
);

  typedef struct packed {
    logic               covered;
    logic [GLYPH_W-1:0] coverage_index;
    logic               order_error;
  } coverage_answer_t;

  localparam int REPORT_CAP = 200;

  logic [FORMAT_W-1:0] fmt_reg;
  logic [ECOUNT_W-1:0] count_reg;
  logic [GLYPH_W-1:0]  start_mem [MAX_ENTRIES];
  logic [GLYPH_W-1:0]  end_mem   [MAX_ENTRIES];
  logic [GLYPH_W-1:0]  base_mem  [MAX_ENTRIES];

  coverage_answer_t coverage_answers_q[$];
  coverage_answer_t want;
  int               results_seen;
  int               reports;

  // applies a load to the shadow table, or binary-searches it for a lookup
  function automatic coverage_answer_t answer_for_item(
    input logic               op,
    input logic [SLOT_W-1:0]  slot,
    input logic [GLYPH_W-1:0] first_g,
    input logic [GLYPH_W-1:0] last_g,
    input logic [GLYPH_W-1:0] base_g,
    input logic [GLYPH_W-1:0] query
  );
    coverage_answer_t   ans;
    int                 lo;
    int                 hi;
    int                 mid;
    logic               ranges;
    logic [GLYPH_W-1:0] s;
    logic [GLYPH_W-1:0] e;
    ans    = '0;
    ranges = (fmt_reg == FMT_RANGES);
    if (op == OP_LOAD) begin
      if (int'(slot) < MAX_ENTRIES) begin
        if (slot != 0 && first_g <= end_mem[slot - 1]) ans.order_error = 1'b1;
        start_mem[slot] = first_g;
        end_mem[slot]   = ranges ? last_g : first_g;
        base_mem[slot]  = ranges ? base_g : '0;
      end
    end else begin
      lo = 0;
      hi = (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg);
      while (lo < hi && !ans.covered) begin
        mid = lo + (hi - lo) / 2;
        s   = start_mem[mid];
        e   = ranges ? end_mem[mid] : s;
        if (query < s) begin
          hi = mid;
        end else if (e < query) begin
          lo = mid + 1;
        end else begin
          ans.covered        = 1'b1;
          ans.coverage_index = ranges ? GLYPH_W'(base_mem[mid] + query - s) : GLYPH_W'(mid);
        end
      end
    end
    return ans;
  endfunction

  task automatic report(input string what, input int expv, input int gotv);
    if (reports < REPORT_CAP)
      $display("%0t: result item %0d %s expected %0d got %0d", $time, results_seen, what,
               expv, gotv);
    reports++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fmt_reg         = FMT_GLYPHS;
      count_reg       = '0;
      coverage_answers_q.delete();
      fail_count      = 0;
      pending         = 0;
      loads_seen      = 0;
      order_errs_seen = 0;
      lookups_seen    = 0;
      hits_seen       = 0;
      results_seen    = 0;
      reports         = 0;
    end else begin
      // result first: an item taken at this edge cannot already be answered
      if (result.valid && result.ready) begin
        if (coverage_answers_q.size() == 0) begin
          if (reports < REPORT_CAP)
            $display("%0t: result item %0d with none expected: covered %0b index %0d error %0b",
                     $time, results_seen, result.covered, result.coverage_index,
                     result.order_error);
          reports++;
          fail_count++;
        end else begin
          want = coverage_answers_q.pop_front();
          if (result.covered !== want.covered) begin
            report("covered", want.covered, result.covered);
            fail_count++;
          end
          if (result.coverage_index !== want.coverage_index) begin
            report("coverage_index", want.coverage_index, result.coverage_index);
            fail_count++;
          end
          if (result.order_error !== want.order_error) begin
            report("order_error", want.order_error, result.order_error);
            fail_count++;
          end
        end
        results_seen++;
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FORMAT: fmt_reg   = cfg.data[FORMAT_W-1:0];
          REG_COUNT:  count_reg = cfg.data[ECOUNT_W-1:0];
          default: ;
        endcase
      end

      if (item.valid && item.ready) begin
        want = answer_for_item(item.op, item.entry_slot, item.first_glyph, item.last_glyph,
                               item.base_index, item.query_glyph);
        coverage_answers_q = {coverage_answers_q, want};
        if (item.op == OP_LOAD) begin
          loads_seen++;
          if (want.order_error) order_errs_seen++;
        end else begin
          lookups_seen++;
          if (want.covered) hits_seen++;
        end
      end

      pending = coverage_answers_q.size();
    end
  end

endmodule

// ----- sim/glyph_coverage_lookup_tb.sv -----
// top of the glyph coverage lookup testbench: clock, reset, item, config and result-ready stimulus
// and the verdict; depends on gcl_pkg, gcl_if, the block and gcl_coverage_checker
`timescale 1ns / 1ps

module glyph_coverage_lookup_tb;
  import gcl_pkg::*;

  localparam logic [FORMAT_W-1:0] FMT_SPARE_LO = 2'd0;
  localparam logic [FORMAT_W-1:0] FMT_SPARE_HI = 2'd3;
  localparam int ITEM_TARGET = 1720;
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst;

  gcl_item_if   item_ch();
  gcl_result_if result_ch();
  gcl_cfg_if    cfg_ch();

  int fail_count;
  int pending;
  int loads_seen;
  int order_errs_seen;
  int lookups_seen;
  int hits_seen;

  // stimulus-side view of the table, only to keep loads legal and aim queries
  int                 filled;
  bit [GLYPH_W-1:0]   slot_lo [MAX_ENTRIES];
  bit [GLYPH_W-1:0]   slot_hi [MAX_ENTRIES];
  logic [FORMAT_W-1:0] cur_format;
  int                 items_sent;
  bit                 no_idle;

  glyph_coverage_lookup dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  gcl_coverage_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .item            (item_ch),
    .result          (result_ch),
    .cfg             (cfg_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .loads_seen      (loads_seen),
    .order_errs_seen (order_errs_seen),
    .lookups_seen    (lookups_seen),
    .hits_seen       (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout: the block stopped answering");
    $display("TEST FAILED");
    $finish;
  end

  // result back-pressure: runs of always-ready, random stalls and long stalls
  initial begin
    int run;
    int mode;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 9);
      run  = (mode == 9) ? $urandom_range(8, 30) : $urandom_range(4, 50);
      repeat (run) begin
        @(negedge clk);
        if (mode < 3)      result_ch.ready <= 1'b1;
        else if (mode < 7) result_ch.ready <= ($urandom_range(0, 3) != 0);
        else if (mode < 9) result_ch.ready <= ($urandom_range(0, 1) != 0);
        else               result_ch.ready <= 1'b0;
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input logic op, input int slot, input int first_g,
                           input int last_g, input int base_g, input int query);
    int g;
    g = gap_len();
    cfg_ch.valid <= 1'b0;
    if (g > 0) begin
      item_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.op          <= op;
    item_ch.entry_slot  <= slot[SLOT_W-1:0];
    item_ch.first_glyph <= first_g[GLYPH_W-1:0];
    item_ch.last_glyph  <= last_g[GLYPH_W-1:0];
    item_ch.base_index  <= base_g[GLYPH_W-1:0];
    item_ch.query_glyph <= query[GLYPH_W-1:0];
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // slot must be 0 or follow a written slot
  task automatic load_entry(input int slot, input int first_g, input int last_g,
                            input int base_g);
    send_item(OP_LOAD, slot, first_g, last_g, base_g, $urandom_range(0, 65535));
    slot_lo[slot] = first_g[GLYPH_W-1:0];
    slot_hi[slot] = (cur_format == FMT_RANGES) ? last_g[GLYPH_W-1:0] : first_g[GLYPH_W-1:0];
    if (slot == filled) filled++;
  endtask

  task automatic lookup_glyph(input int query);
    send_item(OP_LOOKUP, $urandom_range(0, 255), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535), query);
  endtask

  // only once every result item is back
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    if (idx == REG_FORMAT) cur_format = val[FORMAT_W-1:0];
  endtask

  function automatic int glyph_near_table(input int eff);
    int r;
    int i;
    logic [GLYPH_W-1:0] lo_g;
    logic [GLYPH_W-1:0] hi_g;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 8) return 65535;
    if (eff == 0 || r < 30) return $urandom_range(0, 65535);
    i    = $urandom_range(0, eff - 1);
    lo_g = slot_lo[i];
    hi_g = slot_hi[i];
    case ($urandom_range(0, 4))
      0: return lo_g;
      1: return hi_g;
      2: return GLYPH_W'(lo_g - 1'b1);
      3: return GLYPH_W'(hi_g + 1'b1);
      default: return GLYPH_W'(lo_g + (hi_g - lo_g) / 2);
    endcase
  endfunction

  task automatic run_directed();
    no_idle = 1'b0;
    // empty table straight after reset
    lookup_glyph('h0000);
    lookup_glyph('hFFFF);
    // single glyphs, with equal and falling starts flagged
    load_entry(0, 'h0000, 'hFFFF, 'hFFFF);
    load_entry(1, 'h0005, 'h0000, 'h0000);
    load_entry(2, 'h0005, 'h1234, 'h4321);
    load_entry(3, 'h0003, 'h0003, 'h0003);
    load_entry(3, 'hFFFF, 'h0000, 'h1234);
    write_reg(REG_COUNT, 4);
    lookup_glyph('h0000);
    lookup_glyph('h0005);
    lookup_glyph('hFFFF);
    lookup_glyph('h0004);
    // ranges: index wrapping past 65535 and an inverted range
    write_reg(REG_FORMAT, FMT_RANGES);
    load_entry(0, 'h0000, 'h0009, 'hFFFE);
    load_entry(1, 'h0014, 'h000F, 'h0100);
    load_entry(2, 'h0010, 'h0020, 'h0000);
    load_entry(3, 'h0100, 'hFFFF, 'hFFFF);
    lookup_glyph('h0005);
    lookup_glyph('h0012);
    lookup_glyph('hFFFF);
    lookup_glyph('h0050);
    // format switched over stored ranges, then the unused format codes
    write_reg(REG_FORMAT, FMT_GLYPHS);
    lookup_glyph('h0100);
    lookup_glyph('h0005);
    write_reg(REG_FORMAT, FMT_SPARE_HI);
    lookup_glyph('h0014);
    write_reg(REG_FORMAT, FMT_SPARE_LO);
    load_entry(4, 'h00FF, 'h0000, 'hFFFF);
    lookup_glyph('h0000);
  endtask

  // sorted load run, then lookups mixed with a few reloads
  task automatic run_phase(input bit force_full);
    int r;
    int n;
    int span;
    int cur;
    int first_g;
    int last_g;
    int top_g;
    int cnt;
    int eff;
    int s;
    logic [FORMAT_W-1:0] fmt;
    no_idle = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 45)      fmt = FMT_GLYPHS;
    else if (r < 90) fmt = FMT_RANGES;
    else if (r < 95) fmt = FMT_SPARE_LO;
    else             fmt = FMT_SPARE_HI;
    write_reg(REG_FORMAT, fmt);

    r = $urandom_range(0, 99);
    if (force_full || r < 8) n = MAX_ENTRIES;
    else if (r < 28)         n = $urandom_range(17, 64);
    else                     n = $urandom_range(1, 16);
    span = 60000 / (2 * n + 1);
    cur  = $urandom_range(0, 200);
    for (int i = 0; i < n; i++) begin
      first_g = cur;
      last_g  = (fmt == FMT_RANGES) ? cur + $urandom_range(0, span) : $urandom_range(0, 65535);
      top_g   = (fmt == FMT_RANGES) ? last_g : first_g;
      cur     = top_g + 1 + $urandom_range(0, span);
      // occasional out-of-order start or inverted range
      if ($urandom_range(0, 19) == 0) first_g = $urandom_range(0, 65535);
      if (fmt == FMT_RANGES && $urandom_range(0, 24) == 0) last_g = $urandom_range(0, first_g);
      load_entry(i, first_g, last_g, $urandom_range(0, 65535));
    end

    if ($urandom_range(0, 6) == 0) write_reg(REG_FORMAT, $urandom_range(0, 3));

    r = $urandom_range(0, 99);
    if (force_full)                          cnt = (1 << ECOUNT_W) - 1;
    else if (r < 5)                          cnt = 0;
    else if (filled == MAX_ENTRIES && r < 35) cnt = $urandom_range(MAX_ENTRIES, 511);
    else if (r < 50)                         cnt = $urandom_range(0, filled);
    else                                     cnt = n;
    write_reg(REG_COUNT, cnt);
    eff = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt;

    repeat ($urandom_range(15, 50)) begin
      if ($urandom_range(0, 9) == 0) begin
        s = $urandom_range(0, (filled < MAX_ENTRIES) ? filled : MAX_ENTRIES - 1);
        if ($urandom_range(0, 1) == 0)
          load_entry(s, slot_lo[s], slot_hi[s], $urandom_range(0, 65535));
        else
          load_entry(s, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
      end else begin
        lookup_glyph(glyph_near_table(eff));
      end
    end
  endtask

  initial begin
    int phase;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.op          = OP_LOAD;
    item_ch.entry_slot  = '0;
    item_ch.first_glyph = '0;
    item_ch.last_glyph  = '0;
    item_ch.base_index  = '0;
    item_ch.query_glyph = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_FORMAT;
    cfg_ch.data         = '0;
    filled              = 0;
    cur_format          = FMT_GLYPHS;
    items_sent          = 0;
    no_idle             = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase == 0);
      phase++;
    end

    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d loads (%0d out of order) and %0d lookups (%0d covered)",
             loads_seen, order_errs_seen, lookups_seen, hits_seen);
    $display("over %0d table phases: all format codes, entry counts up to 511, full table",
             phase);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
